FILE: rtl/core/stfs_pkg.sv
// ----------------------------------------------------------------------------
// stfs_pkg: shared definitions for the full-step stepper sequencer
// Field widths, reset values, register indexes and the coil pattern lookup.
// ----------------------------------------------------------------------------
package stfs_pkg;

    localparam int unsigned POS_W      = 15;
    localparam int unsigned ELAPSED_W  = 26;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned COIL_W     = 4;
    localparam int unsigned CFG_DATA_W = 26;
    localparam int unsigned CFG_ADDR_W = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_STEPS_PER_REV = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_INTERVAL = 1'b1;

    // Input kind codes.
    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [POS_W-1:0]     SPR_RESET      = 15'd200;
    localparam logic [ELAPSED_W-1:0] INTERVAL_RESET = 26'd300000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = {ELAPSED_W{1'b1}};

    // Full-step drive pattern by phase (bits 3..0 drive wires 1..4).
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b0101;
            2'd3:    pat = 4'b1001;
            default: pat = 4'b1010;
        endcase
        return pat;
    endfunction

endpackage

FILE: rtl/core/stepper_full_step_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_full_step_sequencer: four-wire full-step stepper sequencer
// Turns move commands and microsecond ticks into coil drive words.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle and returns exactly one
// result word for each, in order. A move word (tuser = 0) loads the remaining
// step count with the magnitude of its signed count and sets the direction
// from its sign (a zero count clears the remaining steps and keeps the
// direction). A tick word (tuser = 1) stands for one microsecond: it advances
// a saturating elapsed counter, and when steps remain and the counter has
// reached the step interval the motor takes one step, the position wraps
// modulo the steps per revolution and the coils take the full-step pattern
// of the new phase. All state is updated in the same cycle that the word is
// accepted, and the result sits in a single output register, so a new word
// can enter every cycle as long as the result side keeps taking words. The
// result is valid in the cycle after acceptance. The step interval is given
// in ticks, so the host converts speed into an interval itself. Configuration
// must be written only while idle; the block itself does not enforce this.
module stepper_full_step_sequencer
    import stfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] move_count (signed)
    input  logic                  s_tuser,   // [0] kind

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata    // [3:0] coils, [18:4] position,
                                             // [19] stepped, [20] busy_res,
                                             // [23:21] zero
);

    // Configuration registers.
    logic [POS_W-1:0]     spr_reg;
    logic [ELAPSED_W-1:0] interval_reg;

    // Sequencer state.
    logic [POS_W-1:0]     pos_reg,     pos_next;
    logic                 fwd_reg,     fwd_next;
    logic [COUNT_W-1:0]   rem_reg,     rem_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [COIL_W-1:0]    coil_reg,    coil_next;

    // Output register.
    logic                 out_valid_reg;
    logic [COIL_W-1:0]    out_coils_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic                 out_stepped_reg;
    logic                 out_busy_reg;

    logic                 accept;
    logic                 do_step;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [POS_W-1:0]     wrap_n;
    logic [POS_W:0]       pos_plus;
    logic [POS_W-1:0]     pos_step;
    logic signed [COUNT_W-1:0] move_count;

    // The output register frees up whenever its word is taken.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign move_count = s_tdata;

    // A zero wrap point acts as one, which pins the position at zero.
    assign wrap_n = (spr_reg == '0) ? POS_W'(1) : spr_reg;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + 1'b1;

    assign do_step = (s_tuser == KIND_TICK) && (rem_reg != '0)
                     && (elapsed_inc >= interval_reg);

    // Next position for one step. A position left at or beyond the wrap point
    // after the revolution was shortened goes to zero forward or to the last
    // position backward.
    assign pos_plus = {1'b0, pos_reg} + 1'b1;

    always_comb begin
        if (fwd_reg) begin
            pos_step = (pos_plus >= {1'b0, wrap_n}) ? '0 : pos_plus[POS_W-1:0];
        end else begin
            pos_step = ((pos_reg == '0) || (pos_reg >= wrap_n)) ? wrap_n - 1'b1
                                                                 : pos_reg - 1'b1;
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        fwd_next     = fwd_reg;
        rem_next     = rem_reg;
        elapsed_next = elapsed_reg;
        coil_next    = coil_reg;
        if (s_tuser == KIND_MOVE) begin
            if (move_count == '0) begin
                rem_next = '0;
            end else if (move_count < 0) begin
                // Negating the most negative count gives 32768 as unsigned.
                fwd_next = 1'b0;
                rem_next = COUNT_W'(-move_count);
            end else begin
                fwd_next = 1'b1;
                rem_next = COUNT_W'(move_count);
            end
        end else begin
            elapsed_next = elapsed_inc;
            if (do_step) begin
                pos_next     = pos_step;
                elapsed_next = '0;
                rem_next     = rem_reg - 1'b1;
                coil_next    = coil_pattern(pos_step[1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_reg      <= SPR_RESET;
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_STEPS_PER_REV: spr_reg      <= cfg_wdata[POS_W-1:0];
                REG_STEP_INTERVAL: interval_reg <= cfg_wdata[ELAPSED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            fwd_reg     <= 1'b0;
            rem_reg     <= '0;
            elapsed_reg <= ELAPSED_MAX;
            coil_reg    <= '0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            fwd_reg     <= fwd_next;
            rem_reg     <= rem_next;
            elapsed_reg <= elapsed_next;
            coil_reg    <= coil_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_coils_reg   <= coil_next;
            out_pos_reg     <= pos_next;
            out_stepped_reg <= do_step;
            out_busy_reg    <= (rem_next != '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_busy_reg, out_stepped_reg, out_pos_reg, out_coils_reg};

`ifndef SYNTHESIS
    // A step clears the elapsed counter and uses up exactly one step.
    a_step_updates: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && do_step) |=> (elapsed_reg == '0)
                                && (rem_reg == $past(rem_reg) - 1'b1))
        else $error("step did not clear elapsed or decrement remaining steps");

    // A word that reports a step carries the coil pattern of its position.
    a_step_coils: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_stepped_reg) |-> (out_coils_reg == coil_pattern(out_pos_reg[1:0])))
        else $error("stepped result carries coils that do not match its phase");

    // The busy flag of a freshly loaded result mirrors the remaining count.
    a_busy_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(accept) |-> (out_busy_reg == (rem_reg != '0)))
        else $error("busy flag disagrees with remaining steps");

    // A move never steps and never touches the elapsed counter.
    a_move_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == KIND_MOVE)) |=> (!out_stepped_reg
                                               && $stable(elapsed_reg)))
        else $error("move word stepped or changed elapsed time");
`endif

endmodule

FILE: tb/sv/stepper_full_step_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_full_step_sequencer_tb: self-checking bench for the step sequencer
// Feeds move and tick words through the input stream, forecasts the coil
// drive, position, step flag and busy flag of every word, and compares each
// result word against the forecast while both stream sides stall at random.
// ----------------------------------------------------------------------------
module stepper_full_step_sequencer_tb;
    import stfs_pkg::*;

    // One input word: the kind goes out on tuser, the signed count on tdata.
    typedef struct packed {
        logic    kind;
        shortint count;
    } cmd_t;

    // One result word as the block should return it.
    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic [POS_W-1:0]  position;
        logic              stepped;
        logic              busy;
    } drive_t;

    // Full-step coil patterns, indexed by the low two bits of the position.
    localparam logic [COIL_W-1:0] PHASE_COILS [4] = '{4'b1010, 4'b0110, 4'b0101, 4'b1001};

    // Number of phases in the random part, with their register settings.
    localparam int N_PHASES = 11;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_STEPS_PER_REV;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // [15:0] move_count (signed)
    logic                  s_tuser   = 1'b0; // [0] kind
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // [3:0] coils, [18:4] position,
                                             // [19] stepped, [20] busy_res,
                                             // [23:21] zero

    // Words waiting to be offered, and forecasts waiting for their result word.
    cmd_t   cmd_q[$];
    drive_t drive_forecast_q[$];

    // Bench copy of the sequencer state and its two registers.
    int unsigned       spr_cfg      = SPR_RESET;
    int unsigned       interval_cfg = INTERVAL_RESET;
    int unsigned       pos_st       = 0;
    bit                fwd_st       = 1'b0;
    int unsigned       remain_st    = 0;
    int unsigned       elapsed_st   = ELAPSED_MAX;
    logic [COIL_W-1:0] coil_st      = '0;

    int  err_count = 0;
    bit  in_fire   = 1'b0;  // an input word was taken at the last rising edge
    bit  steady    = 1'b0;  // while set, neither side idles on its own
    int  hold_req  = 0;     // bumped to ask the receiver for a long hold-off

    stepper_full_step_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one accepted word to the bench state and returns the result that
    // the block must produce for it. Only a tick can move the motor.
    function automatic drive_t motor_step(input cmd_t c);
        drive_t      res;
        int unsigned wrap;
        res.stepped = 1'b0;
        if (c.kind == KIND_MOVE) begin
            // A zero count stops the motor but keeps the last direction.
            if (c.count > 0) begin
                fwd_st    = 1'b1;
                remain_st = c.count;
            end else if (c.count < 0) begin
                fwd_st    = 1'b0;
                remain_st = -int'(c.count);
            end else begin
                remain_st = 0;
            end
        end else begin
            if (elapsed_st != ELAPSED_MAX)
                elapsed_st++;
            if (remain_st != 0 && elapsed_st >= interval_cfg) begin
                // A zero revolution size behaves as one. A position left beyond the wrap
                // point by a lowered register goes to zero forward or to the top backward.
                wrap = (spr_cfg == 0) ? 1 : spr_cfg;
                if (fwd_st)
                    pos_st = (pos_st + 1 >= wrap) ? 0 : pos_st + 1;
                else
                    pos_st = (pos_st == 0 || pos_st >= wrap) ? wrap - 1 : pos_st - 1;
                elapsed_st  = 0;
                remain_st--;
                coil_st     = PHASE_COILS[pos_st[1:0]];
                res.stepped = 1'b1;
            end
        end
        res.coils    = coil_st;
        res.position = pos_st[POS_W-1:0];
        res.busy     = (remain_st != 0);
        return res;
    endfunction

    // Sender: a new word goes out once the last one was taken. About one word
    // slot in six is left empty unless a steady stretch is running.
    always @(negedge aclk) begin : drive_inputs
        cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (cmd_q.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
                nxt = cmd_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.kind;
                s_tdata  <= nxt.count;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random, and on request holds tready low for a long
    // stretch so that the output register fills and the input side backs up.
    always @(negedge aclk) begin : drive_ready
        int hold_seen;
        int hold_left;
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = 60;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 16);
        end
    end

    // At each rising edge, check the result word that leaves and forecast the
    // input word that enters. The result is registered, so a word never leaves
    // at the edge where it entered.
    always @(posedge aclk) begin : check_results
        drive_t want;
        in_fire = aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_forecast_q.size() == 0) begin
                $error("result word %h arrived with no forecast waiting", m_tdata);
                err_count++;
            end else begin
                want = drive_forecast_q.pop_front();
                if (m_tdata[3:0] !== want.coils) begin
                    $error("coils: expected %b, got %b", want.coils, m_tdata[3:0]);
                    err_count++;
                end
                if (m_tdata[18:4] !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, m_tdata[18:4]);
                    err_count++;
                end
                if (m_tdata[19] !== want.stepped) begin
                    $error("stepped: expected %b, got %b", want.stepped, m_tdata[19]);
                    err_count++;
                end
                if (m_tdata[20] !== want.busy) begin
                    $error("busy_res: expected %b, got %b", want.busy, m_tdata[20]);
                    err_count++;
                end
                if (m_tdata[23:21] !== 3'b000) begin
                    $error("pad: expected 000, got %b", m_tdata[23:21]);
                    err_count++;
                end
            end
        end
        if (in_fire)
            drive_forecast_q.push_back(motor_step(cmd_t'{kind: s_tuser, count: s_tdata}));
    end

    task automatic add_move(input int cnt);
        cmd_q.push_back(cmd_t'{kind: KIND_MOVE, count: shortint'(cnt)});
    endtask

    // The count field of a tick is ignored, so it carries random bits.
    task automatic add_tick();
        cmd_q.push_back(cmd_t'{kind: KIND_TICK, count: shortint'($urandom())});
    endtask

    // Registers change only with nothing in flight. The bench copy is updated
    // together with the write, since no word can be taken meanwhile.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        if (idx == REG_STEPS_PER_REV)
            spr_cfg = val & 32'h7FFF;
        else
            interval_cfg = val & ELAPSED_MAX;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every word went out and every result came back, so that the
    // block is left fully quiet.
    task automatic wait_idle();
        do @(posedge aclk);
        while (cmd_q.size() != 0 || s_tvalid || drive_forecast_q.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    // Mostly short moves in both directions, some long ones, some fully random
    // counts, and now and then one of the edge counts.
    function automatic int pick_count();
        int r;
        int mag;
        r = $urandom_range(99);
        if (r < 50) begin
            mag = $urandom_range(12, 1);
        end else if (r < 75) begin
            mag = $urandom_range(400, 13);
        end else if (r < 90) begin
            return int'(shortint'($urandom()));
        end else begin
            case ($urandom_range(4))
                0:       return 0;
                1:       return -32768;
                2:       return 32767;
                3:       return -1;
                default: return 1;
            endcase
        end
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // A run is mostly a move followed by a train of ticks, so that moves get
    // carried out over many steps and wrap the position. A few runs are short
    // bursts of arbitrary words instead.
    task automatic add_random_run(input int n_items);
        int left;
        int burst;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(9) == 0) begin
                burst = $urandom_range(4, 1);
                repeat (burst) begin
                    if ($urandom_range(1))
                        add_tick();
                    else
                        add_move(int'(shortint'($urandom())));
                end
                left -= burst;
            end else begin
                add_move(pick_count());
                burst = $urandom_range(24);
                repeat (burst) add_tick();
                left -= burst + 1;
            end
        end
    endtask

    initial begin : stimulus
        int unsigned spr_set [N_PHASES];
        int unsigned ivl_set [N_PHASES];

        spr_set = '{1, 2, 4, 0, 7, 200, 32767, 13, 5,
                    $urandom_range(50, 1), $urandom_range(32767, 1)};
        ivl_set = '{0, 1, 0, 2, 3, 1, 0, 5, ELAPSED_MAX, $urandom_range(3), 0};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: elapsed starts saturated, so the first tick after a
        // move steps at once, and the next one waits out the long interval.
        // Ticks with no steps left show the coils still off.
        add_tick();
        add_move(3);
        add_tick();
        add_tick();
        add_move(0);
        wait_idle();

        // Largest revolution, no interval: the most negative count, then the
        // largest positive one, then a single backward step, each followed by two
        // ticks.
        write_reg(REG_STEPS_PER_REV, 32767);
        write_reg(REG_STEP_INTERVAL, 0);
        add_move(-32768);
        add_tick();
        add_tick();
        add_move(32767);
        add_tick();
        add_tick();
        add_move(-1);
        add_tick();
        add_tick();
        wait_idle();

        // With a lowered wrap point, a backward step from zero lands on the top,
        // and a forward step from the top lands on zero.
        write_reg(REG_STEPS_PER_REV, 5);
        add_move(-1);
        add_tick();
        add_move(1);
        add_tick();
        wait_idle();

        // Same again, with a forward step from beyond the wrap point.
        write_reg(REG_STEPS_PER_REV, 32767);
        add_move(-1);
        add_tick();
        wait_idle();
        write_reg(REG_STEPS_PER_REV, 3);
        add_move(1);
        add_tick();
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(REG_STEPS_PER_REV, spr_set[ph]);
            write_reg(REG_STEP_INTERVAL, ivl_set[ph]);
            // With the longest interval almost nothing steps, so keep it short.
            add_random_run(ivl_set[ph] == ELAPSED_MAX ? 60 : 165);
            if (ph == 2) begin
                // Steady stretch with a long receiver hold-off in the middle:
                // the sender keeps offering while the block backs up.
                steady = 1'b1;
                hold_req++;
            end
            wait_idle();
            steady = 1'b0;
        end

        repeat (5) @(posedge aclk);
        if (err_count == 0 && drive_forecast_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // The watchdog time is far beyond the length of the whole run.
    initial begin : watchdog
        #1ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
